### design/atrs_pkg.sv
`default_nettype none

package atrs_pkg;

  // Machine phases
  localparam logic [1:0] PH_SEND   = 2'd0;
  localparam logic [1:0] PH_WAIT   = 2'd1;
  localparam logic [1:0] PH_RECV   = 2'd2;
  localparam logic [1:0] PH_UNUSED = 2'd3;

  // Status codes
  localparam logic [1:0] ST_PROC  = 2'd0;
  localparam logic [1:0] ST_OK    = 2'd1;
  localparam logic [1:0] ST_FTIME = 2'd2;
  localparam logic [1:0] ST_FRESP = 2'd3;

  // Init steps
  localparam logic [1:0] STEP_RESET = 2'd0;
  localparam logic [1:0] STEP_READY = 2'd1;
  localparam logic [1:0] STEP_ECHO  = 2'd2;
  localparam logic [1:0] STEP_MODE  = 2'd3;

  // Response classes
  localparam logic [1:0] CLS_EXPECTED = 2'd0;
  localparam logic [1:0] CLS_BUSY     = 2'd1;
  localparam logic [1:0] CLS_ASYNC    = 2'd2;
  localparam logic [1:0] CLS_OTHER    = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_TO_RESET  = 3'd0;
  localparam logic [2:0] REG_TO_READY  = 3'd1;
  localparam logic [2:0] REG_TO_ECHO   = 3'd2;
  localparam logic [2:0] REG_TO_MODE   = 3'd3;
  localparam logic [2:0] REG_RET_RESET = 3'd4;
  localparam logic [2:0] REG_RET_ECHO  = 3'd5;
  localparam logic [2:0] REG_BUSY_XTRA = 3'd6;

  localparam int unsigned PADDR_W = 5;

  typedef struct packed {
    logic [15:0] timeout_reset_ms;
    logic [15:0] timeout_ready_ms;
    logic [15:0] timeout_echo_ms;
    logic [15:0] timeout_mode_ms;
    logic [3:0]  retries_reset;
    logic [3:0]  retries_echo;
    logic [15:0] busy_extra_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0] status;
    logic       send_strobe;
    logic [1:0] step_index;
    logic       packet_taken;
  } result_t;

endpackage

`default_nettype wire

### design/atrs_cfg_regs.sv
`default_nettype none

module atrs_cfg_regs (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [atrs_pkg::PADDR_W-1:0]  paddr,
  input  wire [31:0]                   pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output atrs_pkg::cfg_t               cfg_o
);
  import atrs_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  // Write the addressed register, masked to its width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_reset_ms <= 16'd500;
      cfg_q.timeout_ready_ms <= 16'd3000;
      cfg_q.timeout_echo_ms  <= 16'd500;
      cfg_q.timeout_mode_ms  <= 16'd500;
      cfg_q.retries_reset    <= 4'd3;
      cfg_q.retries_echo     <= 4'd3;
      cfg_q.busy_extra_ms    <= 16'd1000;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TO_RESET:  cfg_q.timeout_reset_ms <= pwdata[15:0];
        REG_TO_READY:  cfg_q.timeout_ready_ms <= pwdata[15:0];
        REG_TO_ECHO:   cfg_q.timeout_echo_ms  <= pwdata[15:0];
        REG_TO_MODE:   cfg_q.timeout_mode_ms  <= pwdata[15:0];
        REG_RET_RESET: cfg_q.retries_reset    <= pwdata[3:0];
        REG_RET_ECHO:  cfg_q.retries_echo     <= pwdata[3:0];
        REG_BUSY_XTRA: cfg_q.busy_extra_ms    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_TO_RESET:  prdata = {16'd0, cfg_q.timeout_reset_ms};
      REG_TO_READY:  prdata = {16'd0, cfg_q.timeout_ready_ms};
      REG_TO_ECHO:   prdata = {16'd0, cfg_q.timeout_echo_ms};
      REG_TO_MODE:   prdata = {16'd0, cfg_q.timeout_mode_ms};
      REG_RET_RESET: prdata = {28'd0, cfg_q.retries_reset};
      REG_RET_ECHO:  prdata = {28'd0, cfg_q.retries_echo};
      REG_BUSY_XTRA: prdata = {16'd0, cfg_q.busy_extra_ms};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### design/atrs_core.sv
`default_nettype none

module atrs_core (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      fire_i,
  input  wire [31:0]               now_ms_i,
  input  wire                      packet_ready_i,
  input  wire [1:0]                resp_class_i,
  input  atrs_pkg::cfg_t           cfg_i,
  output atrs_pkg::result_t        res_o
);
  import atrs_pkg::*;

  logic [1:0]  phase_q, phase_d;
  logic [1:0]  step_q, step_d;
  logic [31:0] sent_time_q, sent_time_d;
  logic        busy_q, busy_d;
  logic [3:0]  wait_ret_q, wait_ret_d;
  logic [3:0]  recv_ret_q, recv_ret_d;
  logic [1:0]  cls_q, cls_d;

  logic [15:0] step_to;
  logic [3:0]  max_ret;
  logic [16:0] limit;
  logic [31:0] elapsed;
  logic [1:0]  res;
  logic [1:0]  shown;
  logic        strobe;
  logic        taken;
  logic        fail;

  // Per-step timeout and retry limit
  always_comb begin
    unique case (step_q)
      STEP_RESET: begin
        step_to = cfg_i.timeout_reset_ms;
        max_ret = cfg_i.retries_reset;
      end
      STEP_READY: begin
        step_to = cfg_i.timeout_ready_ms;
        max_ret = 4'd0;
      end
      STEP_ECHO: begin
        step_to = cfg_i.timeout_echo_ms;
        max_ret = cfg_i.retries_echo;
      end
      default: begin
        step_to = cfg_i.timeout_mode_ms;
        max_ret = 4'd0;
      end
    endcase
  end

  assign limit   = {1'b0, step_to} + (busy_q ? {1'b0, cfg_i.busy_extra_ms} : 17'd0);
  assign elapsed = now_ms_i - sent_time_q;

  // Advance the send, wait, receive machine
  always_comb begin
    phase_d     = phase_q;
    sent_time_d = sent_time_q;
    busy_d      = busy_q;
    wait_ret_d  = wait_ret_q;
    recv_ret_d  = recv_ret_q;
    cls_d       = cls_q;
    res         = ST_PROC;
    strobe      = 1'b0;
    taken       = 1'b0;
    unique case (phase_q)
      PH_WAIT: begin
        if (packet_ready_i) begin
          wait_ret_d = 4'd0;
          cls_d      = resp_class_i;
          phase_d    = PH_RECV;
          taken      = 1'b1;
        end else if (elapsed >= {15'd0, limit}) begin
          busy_d  = 1'b0;
          phase_d = PH_SEND;
          if (wait_ret_q < max_ret) begin
            wait_ret_d = wait_ret_q + 4'd1;
          end else begin
            wait_ret_d = 4'd0;
            res        = ST_FTIME;
          end
        end
      end
      PH_RECV: begin
        unique case (cls_q)
          CLS_EXPECTED: begin
            phase_d    = PH_SEND;
            recv_ret_d = 4'd0;
            res        = ST_OK;
          end
          CLS_BUSY: begin
            busy_d  = 1'b1;
            phase_d = PH_WAIT;
          end
          CLS_ASYNC: phase_d = PH_WAIT;
          default: begin
            phase_d = PH_SEND;
            if (recv_ret_q < max_ret) begin
              recv_ret_d = recv_ret_q + 4'd1;
            end else begin
              recv_ret_d = 4'd0;
              res        = ST_FRESP;
            end
          end
        endcase
      end
      default: begin
        // Send phase; the unused code behaves the same
        strobe      = (step_q != STEP_READY);
        sent_time_d = now_ms_i;
        phase_d     = PH_WAIT;
      end
    endcase
  end

  // Move between init steps and pick the status shown
  always_comb begin
    fail   = (res == ST_FTIME) || (res == ST_FRESP);
    step_d = step_q;
    shown  = ST_PROC;
    unique case (step_q)
      STEP_RESET: begin
        if (res == ST_OK) step_d = STEP_READY;
        else if (fail) shown = res;
      end
      STEP_READY: begin
        if (res != ST_PROC) step_d = STEP_ECHO;
      end
      STEP_ECHO: begin
        if (res == ST_OK) begin
          step_d = STEP_MODE;
        end else if (fail) begin
          step_d = STEP_RESET;
          shown  = res;
        end
      end
      default: begin
        if (res != ST_PROC) begin
          step_d = STEP_RESET;
          shown  = res;
        end
      end
    endcase
  end

  // Update state once per accepted poll
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SEND;
      step_q      <= STEP_RESET;
      sent_time_q <= 32'd0;
      busy_q      <= 1'b0;
      wait_ret_q  <= 4'd0;
      recv_ret_q  <= 4'd0;
      cls_q       <= CLS_EXPECTED;
    end else if (fire_i) begin
      phase_q     <= phase_d;
      step_q      <= step_d;
      sent_time_q <= sent_time_d;
      busy_q      <= busy_d;
      wait_ret_q  <= wait_ret_d;
      recv_ret_q  <= recv_ret_d;
      cls_q       <= cls_d;
    end
  end

  assign res_o.status       = shown;
  assign res_o.send_strobe  = strobe;
  assign res_o.step_index   = step_q;
  assign res_o.packet_taken = taken;

`ifndef SYNTH
  a_phase_reachable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_UNUSED)
    else $error("phase left the send, wait, receive set");

  a_send_to_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (phase_q == PH_SEND) |=> (phase_q == PH_WAIT))
    else $error("send phase did not move to wait");

  a_taken_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.packet_taken |=> (phase_q == PH_RECV) && (wait_ret_q == 4'd0))
    else $error("taken packet did not enter receive phase");

  a_ready_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == STEP_READY) |-> !res_o.send_strobe)
    else $error("ready wait sent a command");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(phase_q) && $stable(step_q))
    else $error("state moved without a poll");
`endif

endmodule

`default_nettype wire

### design/at_command_retry_sequencer.sv
// Channel | Handshake                 | Payload
// --------+---------------------------+------------------------------------------------
// in      | in_valid_i / in_ready_o   | now_ms_i, packet_ready_i, resp_class_i
// out     | out_valid_o / out_ready_i | status_o, send_strobe_o, step_index_o,
//         |                           | packet_taken_o
// cfg     | psel/penable/pwrite/pready| paddr, pwdata, prdata (APB, registers at 4*i)
//
// One poll per cycle sustained while the result is taken; an accepted poll passes in order
// through the input register, then once through the step logic into the result register.
// The machine state updates in the same edge that loads the result register.
// A stalled result holds the result register; the input register still takes one
// more poll, then in_ready_o drops until the result moves.
// Reset (rst_ni low, asynchronous) empties both registers and restores the defaults.
`default_nettype none

module at_command_retry_sequencer (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire [31:0]                   now_ms_i,
  input  wire                          packet_ready_i,
  input  wire [1:0]                    resp_class_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [1:0]                   status_o,
  output logic                         send_strobe_o,
  output logic [1:0]                   step_index_o,
  output logic                         packet_taken_o,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [atrs_pkg::PADDR_W-1:0]  paddr,
  input  wire [31:0]                   pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import atrs_pkg::*;

  cfg_t        cfg;
  result_t     res;
  result_t     res_q;
  logic        in_vld_q;
  logic        out_vld_q;
  logic [31:0] now_q;
  logic        pkt_q;
  logic [1:0]  cls_q;
  logic        advance;
  logic        fire;

  atrs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  atrs_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .now_ms_i       (now_q),
    .packet_ready_i (pkt_q),
    .resp_class_i   (cls_q),
    .cfg_i          (cfg),
    .res_o          (res)
  );

  assign advance    = !out_vld_q || out_ready_i;
  assign fire       = in_vld_q && advance;
  assign in_ready_o = !in_vld_q || advance;

  // Hold the accepted item until the step logic takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      now_q <= now_ms_i;
      pkt_q <= packet_ready_i;
      cls_q <= resp_class_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = res_q.status;
  assign send_strobe_o  = res_q.send_strobe;
  assign step_index_o   = res_q.step_index;
  assign packet_taken_o = res_q.packet_taken;

endmodule

`default_nettype wire
